### design/psc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the pressure sensor compensation pipeline.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AC1_AC2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AC3_AC4 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AC5_AC6 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B1_B2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MC_MD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OSS     = 3'd5;

  // Factory defaults
  localparam logic [31:0] RST_AC1_AC2 = 32'h0198FFB8;
  localparam logic [31:0] RST_AC3_AC4 = 32'hC7D17FE5;
  localparam logic [31:0] RST_AC5_AC6 = 32'h7FF55A71;
  localparam logic [31:0] RST_B1_B2   = 32'h182E0004;
  localparam logic [31:0] RST_MC_MD   = 32'hDDF90B34;
  localparam logic [1:0]  RST_OSS     = 2'd2;

  // Compensation constants
  localparam int B6_OFFSET = 4000;
  localparam int B4_BIAS   = 32768;
  localparam int B7_SCALE  = 50000;
  localparam int P_C1      = 3038;
  localparam int P_C2      = 7357;
  localparam int P_C3      = 3791;
  localparam int PRESS_MAX = 262143;
  localparam int TEMP_MAX  = 32767;
  localparam int TEMP_MIN  = -32768;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [23:0] raw_press;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temp_tenths;
    logic [17:0]        press_pa;
    logic               div_error;
  } out_t;

endpackage

### design/pressure_sensor_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// Integer temperature / pressure compensation of a barometric sensor,
// fully pipelined with two restoring dividers, one quotient bit per stage.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | in_valid_i, in_stall_o, in_data_i    | in
//  output  | out_valid_o, out_stall_i, out_data_o | out
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i      | in
//
//  One transaction per cycle unless the output stalls; 72 register stages
//  lie between input and output: the temperature divider (27 one-bit
//  stages), the pressure divider (32 one-bit stages) and 13 other stages.
//  Reset clears all stage valid bits and loads the factory coefficients.
//  Each stage holds when the one behind it is full and cannot move, so
//  bubbles close up and input is taken while a result waits at the output.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  psc_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output psc_pkg::out_t                    out_data_o,
  input  logic                             cfg_we_i,
  input  logic [psc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [psc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import psc_pkg::*;

  localparam int DIV1_W = 27;
  localparam int DIV2_W = 32;
  localparam int ST_A   = 0;
  localparam int ST_B   = 1;
  localparam int ST_D1  = 2;
  localparam int ST_C   = ST_D1 + DIV1_W;
  localparam int ST_D   = ST_C + 1;
  localparam int ST_E   = ST_D + 1;
  localparam int ST_F   = ST_E + 1;
  localparam int ST_G   = ST_F + 1;
  localparam int ST_H   = ST_G + 1;
  localparam int ST_I   = ST_H + 1;
  localparam int ST_D2  = ST_I + 1;
  localparam int ST_J   = ST_D2 + DIV2_W;
  localparam int ST_K   = ST_J + 1;
  localparam int ST_L   = ST_K + 1;
  localparam int ST_M   = ST_L + 1;
  localparam int NSTG   = ST_M + 1;

  typedef struct packed {
    logic [18:0]        rem;
    logic [DIV1_W-1:0]  nq;
    logic [18:0]        dsr;
    logic signed [18:0] x1;
    logic               qneg;
    logic               err;
    logic [18:0]        up;
  } d1_t;

  typedef struct packed {
    logic [16:0]        rem;
    logic [DIV2_W-1:0]  nq;
    logic [16:0]        dsr;
    logic               big;
    logic               err;
    logic signed [15:0] temp;
  } d2_t;

  // ---------------- configuration ----------------
  logic [31:0] cal0_q, cal1_q, cal2_q, cal3_q, cal4_q;
  logic [1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal0_q <= RST_AC1_AC2;
      cal1_q <= RST_AC3_AC4;
      cal2_q <= RST_AC5_AC6;
      cal3_q <= RST_B1_B2;
      cal4_q <= RST_MC_MD;
      oss_q  <= RST_OSS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_AC1_AC2: cal0_q <= cfg_data_i;
        CFG_AC3_AC4: cal1_q <= cfg_data_i;
        CFG_AC5_AC6: cal2_q <= cfg_data_i;
        CFG_B1_B2:   cal3_q <= cfg_data_i;
        CFG_MC_MD:   cal4_q <= cfg_data_i;
        CFG_OSS:     oss_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;
  assign ac1 = cal0_q[31:16];
  assign ac2 = cal0_q[15:0];
  assign ac3 = cal1_q[31:16];
  assign ac4 = cal1_q[15:0];
  assign ac5 = cal2_q[31:16];
  assign ac6 = cal2_q[15:0];
  assign b1  = cal3_q[31:16];
  assign b2  = cal3_q[15:0];
  assign mc  = cal4_q[31:16];
  assign md  = cal4_q[15:0];

  // ---------------- flow control ----------------
  logic [NSTG-1:0] vld_q, vld_d, rdy;

  assign rdy[NSTG-1] = !vld_q[NSTG-1] || !out_stall_i;
  for (genvar k = 0; k < NSTG-1; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end
  assign vld_d = {vld_q[NSTG-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) vld_q[k] <= vld_d[k];
      end
    end
  end

  assign in_stall_o  = !rdy[ST_A];
  assign out_valid_o = vld_q[ST_M];

  // ---------------- A: (UT - ac6) * ac5, UP ----------------
  logic signed [16:0] a_diff;
  logic signed [33:0] a_prod;
  logic [3:0]         a_sh;
  logic [23:0]        a_upw;
  logic signed [33:0] a_prod_q;
  logic [18:0]        a_up_q;

  assign a_diff = $signed({1'b0, in_data_i.raw_temp}) - $signed({1'b0, ac6});
  assign a_prod = a_diff * $signed({1'b0, ac5});
  assign a_sh   = 4'd8 - {2'b00, oss_q};
  assign a_upw  = in_data_i.raw_press >> a_sh;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_A]) begin
      a_prod_q <= a_prod;
      a_up_q   <= a_upw[18:0];
    end
  end

  // ---------------- B: X1, divisor and dividend magnitudes ----------------
  logic signed [33:0] b_adj, b_shf;
  logic signed [18:0] b_x1;
  logic signed [19:0] b_den;
  logic [19:0]        b_dabs;
  logic [15:0]        b_mcabs;
  d1_t                b_d;
  d1_t                b_q;

  assign b_adj   = a_prod_q + (a_prod_q[33] ? 34'sd32767 : 34'sd0);
  assign b_shf   = b_adj >>> 15;
  assign b_x1    = b_shf[18:0];
  assign b_den   = b_x1 + md;
  assign b_dabs  = b_den[19] ? 20'(-b_den) : 20'(b_den);
  assign b_mcabs = mc[15] ? 16'(-mc) : 16'(mc);

  always_comb begin
    b_d      = '0;
    b_d.rem  = '0;
    b_d.nq   = {b_mcabs, 11'd0};
    b_d.dsr  = b_dabs[18:0];
    b_d.x1   = b_x1;
    b_d.qneg = mc[15] ^ b_den[19];
    b_d.err  = (b_den == 20'sd0);
    b_d.up   = a_up_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_B]) b_q <= b_d;
  end

  // ---------------- temperature divider: |mc*2^11| / |X1+md| ----------------
  d1_t d1_q   [DIV1_W];
  d1_t d1_nxt [DIV1_W];

  for (genvar j = 0; j < DIV1_W; j++) begin : g_div1
    d1_t         src;
    logic [19:0] rr, sub;
    logic        ge;
    if (j == 0) begin : g_first
      assign src = b_q;
    end else begin : g_rest
      assign src = d1_q[j-1];
    end
    assign rr  = {src.rem, src.nq[DIV1_W-1]};
    assign ge  = rr >= {1'b0, src.dsr};
    assign sub = rr - {1'b0, src.dsr};
    always_comb begin
      d1_nxt[j]     = src;
      d1_nxt[j].rem = ge ? sub[18:0] : rr[18:0];
      d1_nxt[j].nq  = {src.nq[DIV1_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DIV1_W; j++) begin
      if (rdy[ST_D1+j]) d1_q[j] <= d1_nxt[j];
    end
  end

  // ---------------- C: B5, B6 ----------------
  d1_t                c_src;
  logic signed [27:0] c_qs;
  logic signed [28:0] c_b5;
  logic signed [29:0] c_b6;
  logic signed [28:0] c_b5_q;
  logic signed [29:0] c_b6_q;
  logic               c_err_q;
  logic [18:0]        c_up_q;

  assign c_src = d1_q[DIV1_W-1];
  assign c_qs  = c_src.qneg ? -$signed({1'b0, c_src.nq}) : $signed({1'b0, c_src.nq});
  assign c_b5  = c_src.x1 + c_qs;
  assign c_b6  = c_b5 - 30'sd4000;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_C]) begin
      c_b5_q  <= c_b5;
      c_b6_q  <= c_b6;
      c_err_q <= c_src.err;
      c_up_q  <= c_src.up;
    end
  end

  // ---------------- D: B6^2, ac2*B6, ac3*B6, temperature ----------------
  logic signed [59:0] d_sqp;
  logic signed [45:0] d_m2, d_m3;
  logic signed [28:0] d_tt;
  logic signed [15:0] d_temp;
  logic signed [59:0] d_sqp_q;
  logic signed [45:0] d_m2_q, d_m3_q;
  logic signed [15:0] d_temp_q;
  logic               d_err_q;
  logic [18:0]        d_up_q;

  assign d_sqp = c_b6_q * c_b6_q;
  assign d_m2  = ac2 * c_b6_q;
  assign d_m3  = ac3 * c_b6_q;
  assign d_tt  = (c_b5_q + 29'sd8) >>> 4;

  always_comb begin
    if (d_tt > 29'(TEMP_MAX)) begin
      d_temp = 16'(TEMP_MAX);
    end else if (d_tt < 29'(TEMP_MIN)) begin
      d_temp = 16'(TEMP_MIN);
    end else begin
      d_temp = d_tt[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_D]) begin
      d_sqp_q  <= d_sqp;
      d_m2_q   <= d_m2;
      d_m3_q   <= d_m3;
      d_temp_q <= d_temp;
      d_err_q  <= c_err_q;
      d_up_q   <= c_up_q;
    end
  end

  // ---------------- E: partial products of b2*sq, b1*sq ----------------
  logic [43:0]        e_sq;
  logic signed [38:0] e_b2l, e_b2h, e_b1l, e_b1h;
  logic signed [45:0] e_m2s, e_m3s;
  logic signed [38:0] e_b2l_q, e_b2h_q, e_b1l_q, e_b1h_q;
  logic signed [34:0] e_x2a_q;
  logic signed [32:0] e_x1b_q;
  logic signed [15:0] e_temp_q;
  logic               e_err_q;
  logic [18:0]        e_up_q;

  assign e_sq  = d_sqp_q[55:12];
  assign e_b2l = b2 * $signed({1'b0, e_sq[21:0]});
  assign e_b2h = b2 * $signed({1'b0, e_sq[43:22]});
  assign e_b1l = b1 * $signed({1'b0, e_sq[21:0]});
  assign e_b1h = b1 * $signed({1'b0, e_sq[43:22]});
  assign e_m2s = d_m2_q >>> 11;
  assign e_m3s = d_m3_q >>> 13;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_E]) begin
      e_b2l_q  <= e_b2l;
      e_b2h_q  <= e_b2h;
      e_b1l_q  <= e_b1l;
      e_b1h_q  <= e_b1h;
      e_x2a_q  <= e_m2s[34:0];
      e_x1b_q  <= e_m3s[32:0];
      e_temp_q <= d_temp_q;
      e_err_q  <= d_err_q;
      e_up_q   <= d_up_q;
    end
  end

  // ---------------- F: combine partials ----------------
  logic signed [60:0] f_b2sq, f_b1sq;
  logic signed [49:0] f_x1a_q;
  logic signed [44:0] f_x2b_q;
  logic signed [34:0] f_x2a_q;
  logic signed [32:0] f_x1b_q;
  logic signed [15:0] f_temp_q;
  logic               f_err_q;
  logic [18:0]        f_up_q;

  assign f_b2sq = $signed({e_b2h_q, 22'd0}) + $signed({{22{e_b2l_q[38]}}, e_b2l_q});
  assign f_b1sq = $signed({e_b1h_q, 22'd0}) + $signed({{22{e_b1l_q[38]}}, e_b1l_q});

  always_ff @(posedge clk_i) begin
    if (rdy[ST_F]) begin
      f_x1a_q  <= f_b2sq[60:11];
      f_x2b_q  <= f_b1sq[60:16];
      f_x2a_q  <= e_x2a_q;
      f_x1b_q  <= e_x1b_q;
      f_temp_q <= e_temp_q;
      f_err_q  <= e_err_q;
      f_up_q   <= e_up_q;
    end
  end

  // ---------------- G: B3 and the B4 operand ----------------
  logic signed [50:0] g_x3;
  logic signed [51:0] g_n0;
  logic signed [54:0] g_n;
  logic signed [55:0] g_m, g_madj;
  logic signed [45:0] g_s;
  logic [31:0]        g_b3lo_q, g_t32_q;
  logic signed [15:0] g_temp_q;
  logic               g_err_q;
  logic [18:0]        g_up_q;

  assign g_x3   = f_x1a_q + f_x2a_q;
  assign g_n0   = ac1 * 52'sd4 + g_x3;
  assign g_n    = g_n0 <<< oss_q;
  assign g_m    = g_n + 56'sd2;
  // truncating divide by 4
  assign g_madj = g_m + (g_m[55] ? 56'sd3 : 56'sd0);
  assign g_s    = f_x1b_q + f_x2b_q + 46'sd2;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_G]) begin
      g_b3lo_q <= g_madj[33:2];
      g_t32_q  <= g_s[33:2] + 32'(B4_BIAS);
      g_temp_q <= f_temp_q;
      g_err_q  <= f_err_q;
      g_up_q   <= f_up_q;
    end
  end

  // ---------------- H: B4, UP - B3 ----------------
  logic [47:0]        h_prod;
  logic [16:0]        h_b4_q;
  logic [31:0]        h_diff_q;
  logic signed [15:0] h_temp_q;
  logic               h_err_q;

  assign h_prod = ac4 * g_t32_q;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_H]) begin
      h_b4_q   <= h_prod[31:15];
      h_diff_q <= {13'd0, g_up_q} - g_b3lo_q;
      h_temp_q <= g_temp_q;
      h_err_q  <= g_err_q;
    end
  end

  // ---------------- I: B7 ----------------
  logic [15:0]        i_scale;
  logic [47:0]        i_prod;
  logic [31:0]        i_b7_q;
  logic [16:0]        i_b4_q;
  logic signed [15:0] i_temp_q;
  logic               i_err_q;

  assign i_scale = 16'(B7_SCALE >> oss_q);
  assign i_prod  = h_diff_q * i_scale;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_I]) begin
      i_b7_q   <= i_prod[31:0];
      i_b4_q   <= h_b4_q;
      i_temp_q <= h_temp_q;
      i_err_q  <= h_err_q || (h_b4_q == 17'd0);
    end
  end

  // ---------------- pressure divider: B7 (x2 when it fits) / B4 ----------------
  d2_t d2_init;
  d2_t d2_q   [DIV2_W];
  d2_t d2_nxt [DIV2_W];

  always_comb begin
    d2_init      = '0;
    d2_init.rem  = '0;
    d2_init.nq   = i_b7_q[31] ? i_b7_q : {i_b7_q[30:0], 1'b0};
    d2_init.dsr  = i_b4_q;
    d2_init.big  = i_b7_q[31];
    d2_init.err  = i_err_q;
    d2_init.temp = i_temp_q;
  end

  for (genvar j = 0; j < DIV2_W; j++) begin : g_div2
    d2_t         src;
    logic [17:0] rr, sub;
    logic        ge;
    if (j == 0) begin : g_first
      assign src = d2_init;
    end else begin : g_rest
      assign src = d2_q[j-1];
    end
    assign rr  = {src.rem, src.nq[DIV2_W-1]};
    assign ge  = rr >= {1'b0, src.dsr};
    assign sub = rr - {1'b0, src.dsr};
    always_comb begin
      d2_nxt[j]     = src;
      d2_nxt[j].rem = ge ? sub[16:0] : rr[16:0];
      d2_nxt[j].nq  = {src.nq[DIV2_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DIV2_W; j++) begin
      if (rdy[ST_D2+j]) d2_q[j] <= d2_nxt[j];
    end
  end

  // ---------------- J: p, (p>>8)^2, 7357*p ----------------
  d2_t                j_src;
  logic [32:0]        j_p;
  logic [24:0]        j_pd;
  logic [49:0]        j_sq_q;
  logic [45:0]        j_pm_q;
  logic [32:0]        j_p_q;
  logic signed [15:0] j_temp_q;
  logic               j_err_q;

  assign j_src = d2_q[DIV2_W-1];
  assign j_p   = j_src.big ? {j_src.nq, 1'b0} : {1'b0, j_src.nq};
  assign j_pd  = j_p[32:8];

  always_ff @(posedge clk_i) begin
    if (rdy[ST_J]) begin
      j_sq_q   <= j_pd * j_pd;
      j_pm_q   <= j_p * 13'(P_C2);
      j_p_q    <= j_p;
      j_temp_q <= j_src.temp;
      j_err_q  <= j_src.err;
    end
  end

  // ---------------- K: partials of 3038 * x1 ----------------
  logic [36:0]        k_pl_q, k_ph_q;
  logic [45:0]        k_pm_q;
  logic [32:0]        k_p_q;
  logic signed [15:0] k_temp_q;
  logic               k_err_q;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_K]) begin
      k_pl_q   <= j_sq_q[24:0] * 12'(P_C1);
      k_ph_q   <= j_sq_q[49:25] * 12'(P_C1);
      k_pm_q   <= j_pm_q;
      k_p_q    <= j_p_q;
      k_temp_q <= j_temp_q;
      k_err_q  <= j_err_q;
    end
  end

  // ---------------- L: shifted correction terms ----------------
  logic [61:0]        l_a;
  logic signed [46:0] l_neg;
  logic [45:0]        l_a_q;
  logic signed [30:0] l_x2_q;
  logic [32:0]        l_p_q;
  logic signed [15:0] l_temp_q;
  logic               l_err_q;

  assign l_a   = {k_ph_q, 25'd0} + {25'd0, k_pl_q};
  assign l_neg = -$signed({1'b0, k_pm_q});

  always_ff @(posedge clk_i) begin
    if (rdy[ST_L]) begin
      l_a_q    <= l_a[61:16];
      l_x2_q   <= l_neg[46:16];
      l_p_q    <= k_p_q;
      l_temp_q <= k_temp_q;
      l_err_q  <= k_err_q;
    end
  end

  // ---------------- M: final pressure, output register ----------------
  logic signed [47:0] m_sum, m_pf;
  logic signed [43:0] m_corr;
  logic [17:0]        m_press;
  out_t               m_out;
  out_t               out_q;

  assign m_sum  = $signed({2'b00, l_a_q}) + l_x2_q + 48'sd3791;
  assign m_corr = m_sum[47:4];
  assign m_pf   = $signed({15'd0, l_p_q}) + m_corr;

  always_comb begin
    if (m_pf < 48'sd0) begin
      m_press = '0;
    end else if (m_pf > 48'(PRESS_MAX)) begin
      m_press = 18'(PRESS_MAX);
    end else begin
      m_press = m_pf[17:0];
    end
    m_out = '0;
    if (l_err_q) begin
      m_out.div_error = 1'b1;
    end else begin
      m_out.temp_tenths = l_temp_q;
      m_out.press_pa    = m_press;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_M]) out_q <= m_out;
  end

  assign out_data_o = out_q;

  // ---------------- assertions ----------------
  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // input held back only when the first stage holds a transaction
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> vld_q[ST_A])
    else $error("input stalled with an empty first stage");

  // transactions in flight change only by accepts
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> $countones(vld_q) ==
      $past($countones(vld_q)) + $past(32'(in_acc)) - $past(32'(out_acc)))
    else $error("pipeline lost or duplicated a transaction");

  // pressure divider remainder stays below a nonzero divisor
  a_div2_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_D2+DIV2_W-1] && !d2_q[DIV2_W-1].err) |->
      (d2_q[DIV2_W-1].rem < d2_q[DIV2_W-1].dsr))
    else $error("pressure divider remainder out of range");

  // temperature divider remainder likewise
  a_div1_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_D1+DIV1_W-1] && !d1_q[DIV1_W-1].err) |->
      (d1_q[DIV1_W-1].rem < d1_q[DIV1_W-1].dsr))
    else $error("temperature divider remainder out of range");

endmodule

### verif/tb_pressure_sensor_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pressure_sensor_compensation
// Self-checking testbench for the compensation pipeline. Each accepted pair
// goes through a local integer model of the compensation. The expected
// readings are queued and compared field by field with the output stream.
// Phases change the calibration and the handshake pressure.
// ----------------------------------------------------------------------------
module tb_pressure_sensor_compensation;
  import psc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int DRAIN_CYCLES = 90;
  localparam int MAX_CYCLES   = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pressure_sensor_compensation DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // calibration copy used for prediction
  logic [31:0] cal_q[5];
  logic [1:0]  oss_q;

  in_t  pending_pairs[$];
  out_t expected_readings[$];
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   hold_left = 0;
  int   hold_req = 0;
  bit   took = 0;
  int   errors = 0;
  int   cycles = 0;

  function automatic longint sx16(logic [15:0] h);
    return longint'(signed'(h));
  endfunction

  function automatic out_t compensate(in_t pair);
    out_t r;
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
    longint x1, x2, x3, den, b5, b6, b3, sq, p, t;
    longint unsigned up, b4, b7, q;
    int oss;
    oss = int'(oss_q);
    ac1 = sx16(cal_q[0][31:16]); ac2 = sx16(cal_q[0][15:0]);
    ac3 = sx16(cal_q[1][31:16]); ac4 = longint'(cal_q[1][15:0]);
    ac5 = longint'(cal_q[2][31:16]); ac6 = longint'(cal_q[2][15:0]);
    b1 = sx16(cal_q[3][31:16]);  b2 = sx16(cal_q[3][15:0]);
    mc = sx16(cal_q[4][31:16]);  md = sx16(cal_q[4][15:0]);
    ut = longint'(pair.raw_temp);
    up = 64'(pair.raw_press) >> (8 - oss);
    r = '0;
    r.div_error = 1'b1;
    x1 = ((ut - ac6) * ac5) / 32768;
    den = x1 + md;
    if (den == 0) return r;
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    b6 = b5 - B6_OFFSET;
    sq = (b6 * b6) >>> 12;
    x1 = (b2 * sq) >>> 11;
    x2 = (ac2 * b6) >>> 11;
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) / 4;
    x1 = (ac3 * b6) >>> 13;
    x2 = (b1 * sq) >>> 16;
    x3 = (x1 + x2 + 2) >>> 2;
    b4 = ((ac4 * ((x3 + B4_BIAS) & 64'hFFFF_FFFF)) & 64'hFFFF_FFFF) >> 15;
    if (b4 == 0) return r;
    b7 = (((up - (b3 & 64'hFFFF_FFFF)) & 64'hFFFF_FFFF) * (B7_SCALE >> oss))
         & 64'hFFFF_FFFF;
    if (b7 < 64'h8000_0000) q = (b7 * 2) / b4;
    else q = (b7 / b4) * 2;
    p = longint'(q);
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * P_C1) >>> 16;
    x2 = (-P_C2 * p) >>> 16;
    p = p + ((x1 + x2 + P_C3) >>> 4);
    if (p < 0) p = 0;
    if (p > PRESS_MAX) p = PRESS_MAX;
    t = (b5 + 8) >>> 4;
    if (t > TEMP_MAX) t = TEMP_MAX;
    if (t < TEMP_MIN) t = TEMP_MIN;
    r.temp_tenths = t[15:0];
    r.press_pa = p[17:0];
    r.div_error = 1'b0;
    return r;
  endfunction

  // driver: a held item stays until accepted
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || took)) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_pairs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t want;
    cycles <= cycles + 1;
    took <= in_valid && !in_stall;
    if (in_valid && !in_stall) expected_readings.push_back(compensate(in_data));
    if (out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected transaction %p", $time, out_data);
      end else begin
        want = expected_readings.pop_front();
        if (out_data.temp_tenths !== want.temp_tenths) begin
          errors = errors + 1;
          $display("%0t: temp_tenths expected %0d got %0d", $time,
                   want.temp_tenths, out_data.temp_tenths);
        end
        if (out_data.press_pa !== want.press_pa) begin
          errors = errors + 1;
          $display("%0t: press_pa expected %0d got %0d", $time,
                   want.press_pa, out_data.press_pa);
        end
        if (out_data.div_error !== want.div_error) begin
          errors = errors + 1;
          $display("%0t: div_error expected %0b got %0b", $time,
                   want.div_error, out_data.div_error);
        end
      end
    end
    if (cycles > MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    if (idx == CFG_OSS) oss_q = val[1:0];
    else if (idx < CFG_OSS) cal_q[idx] = val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_cal(logic [31:0] r0, r1, r2, r3, r4, logic [1:0] oss);
    write_reg(CFG_AC1_AC2, r0);
    write_reg(CFG_AC3_AC4, r1);
    write_reg(CFG_AC5_AC6, r2);
    write_reg(CFG_B1_B2, r3);
    write_reg(CFG_MC_MD, r4);
    write_reg(CFG_OSS, {30'd0, oss});
  endtask

  task automatic wait_idle();
    while (pending_pairs.size() > 0 || in_valid || expected_readings.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_pair(logic [15:0] ut, logic [23:0] up);
    in_t it;
    it.raw_temp = ut;
    it.raw_press = up;
    pending_pairs.push_back(it);
  endtask

  task automatic push_random(int n);
    repeat (n) begin
      if ($urandom_range(3) == 0) push_pair(16'($urandom), 24'($urandom));
      else push_pair(16'($urandom_range(20000, 34000)),
                     24'($urandom_range(24'h500000, 24'hB00000)));
    end
  endtask

  initial begin
    cal_q[0] = RST_AC1_AC2; cal_q[1] = RST_AC3_AC4; cal_q[2] = RST_AC5_AC6;
    cal_q[3] = RST_B1_B2;   cal_q[4] = RST_MC_MD;   oss_q = RST_OSS;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values, field extremes
    push_pair(16'h0000, 24'h000000);
    push_pair(16'hFFFF, 24'hFFFFFF);
    push_pair(16'd27898, 24'h5D2300);
    push_pair(16'h0000, 24'hFFFFFF);
    push_pair(16'hFFFF, 24'h000000);
    wait_idle();
    // writes to an unused index must not disturb anything
    write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
    // zero temperature divisor: ac5 = 0, md = 0
    write_cal(RST_AC1_AC2, RST_AC3_AC4, 32'h0000_5A71, RST_B1_B2, 32'hDDF9_0000, 2'd0);
    push_pair(16'd27898, 24'h5D2300);
    push_pair(16'hFFFF, 24'hFFFFFF);
    wait_idle();
    // zero pressure divisor: ac4 = 0
    write_cal(RST_AC1_AC2, 32'hC7D1_0000, RST_AC5_AC6, RST_B1_B2, RST_MC_MD, 2'd3);
    push_pair(16'd27898, 24'h5D2300);
    push_pair(16'h1234, 24'h123456);
    wait_idle();
    // temperature saturation: den = 1, mc most negative, then most positive
    write_cal(RST_AC1_AC2, RST_AC3_AC4, 32'h0000_5A71, RST_B1_B2, 32'h8000_0001, 2'd1);
    push_pair(16'd100, 24'h800000);
    wait_idle();
    write_reg(CFG_MC_MD, 32'h7FFF_0001);
    push_pair(16'd100, 24'h800000);
    wait_idle();
    // all ones / all zeros calibration
    write_cal('1, '1, '1, '1, '1, 2'd3);
    push_pair(16'hFFFF, 24'hFFFFFF);
    push_pair(16'h0000, 24'h000001);
    wait_idle();
    write_cal('0, '0, '0, '0, '0, 2'd0);
    push_pair(16'hAAAA, 24'h555555);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 62; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
        default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
      endcase
      if (ph < 4) begin
        write_cal(RST_AC1_AC2 ^ $urandom_range(255), RST_AC3_AC4 ^ $urandom_range(255),
                  RST_AC5_AC6 ^ $urandom_range(255), RST_B1_B2 ^ $urandom_range(255),
                  RST_MC_MD ^ $urandom_range(255), ph[1:0]);
      end else begin
        write_cal($urandom, $urandom, $urandom, $urandom, $urandom,
                  2'($urandom_range(3)));
      end
      push_random(55);
      if (ph == 2) hold_req = 400;  // block fills and stalls its input
      push_random(55);
      wait_idle();
    end

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
